// ===== rtl/mctq_pkg.sv =====
//----------------------------------------------------------------------------
// mctq_pkg
// Shared types and constants for the multi-chip target queues.
//----------------------------------------------------------------------------
package mctq_pkg;

   localparam int CHANNELS_DEF    = 2;
   localparam int RANKS_DEF       = 2;
   localparam int CHIPS_DEF       = 8;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int TAG_W     = 52;
   localparam int TIME_W    = 48;
   localparam int LIMIT_W   = 5;
   localparam int MASK_W    = 8;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [1:0] {
      FUNC_CHECK_ENQ = 2'd0,
      FUNC_ENQ       = 2'd1,
      FUNC_CHECK_RDY = 2'd2,
      FUNC_CONSUME   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHIP,
      ST_READ,
      ST_CMP,
      ST_APPLY,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/multi_chip_target_queues.sv =====
//----------------------------------------------------------------------------
// multi_chip_target_queues
// One FIFO per channel, rank and chip, with check, push, ready and pop
// transactions that span a mask of chips.
//----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the one result strobes on rsp_valid for a single cycle, which
// the receiver cannot stall. A single sequencer walks the chip positions one
// at a time through one tag/due memory read port and one compare unit: every
// chip position is visited, spanned or not, and the memory is read once per
// stored entry of a queue below its limit for check-enqueue, once at the head
// for check-ready and not otherwise. A successful enqueue or consume adds an
// apply pass over every chip position before the transaction closes.
module multi_chip_target_queues #(
   parameter int CHANNELS    = mctq_pkg::CHANNELS_DEF,
   parameter int RANKS       = mctq_pkg::RANKS_DEF,
   parameter int CHIPS       = mctq_pkg::CHIPS_DEF,
   parameter int QUEUE_DEPTH = mctq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_func,
   input  logic                         req_channel,
   input  logic                         req_rank,
   input  logic [mctq_pkg::MASK_W-1:0]  req_chip_mask,
   input  logic [7:0]                   req_context_id,
   input  logic [15:0]                  req_group_id,
   input  logic [15:0]                  req_occurrence_index,
   input  logic [7:0]                   req_command_code,
   input  logic [3:0]                   req_operand_slot,
   input  logic [mctq_pkg::TIME_W-1:0]  req_ready_time,
   input  logic [mctq_pkg::TIME_W-1:0]  req_now_time,
   output logic                         rsp_valid,
   output logic                         rsp_allowed,
   output logic                         rsp_fault,
   input  logic                         csr_we,
   input  logic [mctq_pkg::LIMIT_W-1:0] csr_wdata
);
   import mctq_pkg::*;

   localparam int NQ    = CHANNELS * RANKS * CHIPS;
   localparam int QW    = (NQ > 1) ? $clog2(NQ) : 1;
   localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int NCH   = (CHIPS < MASK_W) ? CHIPS : MASK_W;
   localparam int CHW   = $clog2(NCH + 1);
   localparam int MD    = NQ * QUEUE_DEPTH;
   localparam int AW    = (MD > 1) ? $clog2(MD) : 1;
   localparam int CHNW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RKW   = (RANKS > 1) ? $clog2(RANKS) : 1;
   localparam logic [TAG_W-1:0] DUP_MASK = {8'hFF, 16'h0, 16'hFFFF, 12'h0};

   logic [TAG_W-1:0]  tag_mem [MD];
   logic [TIME_W-1:0] due_mem [MD];
   logic [PW-1:0]     head_ff [NQ];
   logic [CW-1:0]     fill_ff [NQ];

   state_type         state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff;
   func_type          func_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [TIME_W-1:0] due_ff, now_ff;
   logic [QW-1:0]     base_ff;
   logic              range_ok_ff;
   logic              apply_ff, apply_in;
   logic [CHW-1:0]    chip_ff, chip_in;
   logic [CW-1:0]     off_ff, off_in;
   logic              ok_ff, ok_in, fault_ff, fault_in;
   logic [TAG_W-1:0]  rd_tag_ff;
   logic [TIME_W-1:0] rd_due_ff;
   logic              rsp_valid_ff, rsp_allowed_ff, rsp_fault_ff;

   logic [QW-1:0]     q_cur;
   logic [CW-1:0]     fill_cur;
   logic [PW-1:0]     head_cur;
   logic [CW-1:0]     limit_eff;
   logic [CW-1:0]     off_sel;
   logic [CW:0]       slot_sum;
   logic [PW-1:0]     slot_off;
   logic [AW-1:0]     rd_addr;
   logic              chip_sel;
   logic              mem_we;
   logic              req_range_ok;

   assign req_range_ok = (32'(req_channel) < CHANNELS) && (32'(req_rank) < RANKS);
   assign q_cur    = QW'(32'(base_ff) + 32'(chip_ff));
   assign fill_cur = fill_ff[q_cur];
   assign head_cur = head_ff[q_cur];
   assign limit_eff = (32'(limit_ff) > QUEUE_DEPTH) ? CW'(QUEUE_DEPTH) : CW'(limit_ff);
   assign off_sel  = (state_ff == ST_APPLY) ? fill_cur : off_ff;
   assign slot_sum = (CW+1)'(head_cur) + (CW+1)'(off_sel);
   assign slot_off = PW'((32'(slot_sum) >= QUEUE_DEPTH) ?
                         32'(slot_sum) - QUEUE_DEPTH : 32'(slot_sum));
   assign rd_addr  = AW'(32'(q_cur) * QUEUE_DEPTH + 32'(slot_off));
   assign chip_sel = (32'(chip_ff) < NCH) ? mask_ff[3'(chip_ff)] : 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         apply_ff     <= 1'b0;
         chip_ff      <= '0;
         off_ff       <= '0;
         ok_ff        <= 1'b1;
         fault_ff     <= 1'b0;
         for (int i = 0; i < NQ; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         apply_ff     <= apply_in;
         chip_ff      <= chip_in;
         off_ff       <= off_in;
         ok_ff        <= ok_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (state_ff == ST_APPLY && chip_sel) begin
            if (func_ff == FUNC_ENQ) begin
               fill_ff[q_cur] <= fill_cur + CW'(1);
            end else begin
               fill_ff[q_cur] <= fill_cur - CW'(1);
               head_ff[q_cur] <= (32'(head_cur) == QUEUE_DEPTH - 1) ? '0 :
                                 head_cur + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         func_ff     <= func_type'(req_func);
         mask_ff     <= req_chip_mask;
         tag_ff      <= {req_context_id, req_group_id, req_occurrence_index,
                         req_command_code, req_operand_slot};
         due_ff      <= req_ready_time;
         now_ff      <= req_now_time;
         range_ok_ff <= req_range_ok;
         base_ff     <= QW'((32'(CHNW'(req_channel)) * RANKS + 32'(RKW'(req_rank)))
                            * CHIPS);
      end
      if (state_ff == ST_DONE) begin
         rsp_allowed_ff <= ok_ff;
         rsp_fault_ff   <= fault_ff;
      end
   end

   assign mem_we = (state_ff == ST_APPLY) && chip_sel && (func_ff == FUNC_ENQ);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[rd_addr] <= tag_ff;
         due_mem[rd_addr] <= due_ff;
      end
      rd_tag_ff <= tag_mem[rd_addr];
      rd_due_ff <= due_mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      apply_in = apply_ff;
      chip_in  = chip_ff;
      off_in   = off_ff;
      ok_in    = ok_ff;
      fault_in = fault_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               chip_in  = '0;
               off_in   = '0;
               apply_in = 1'b0;
               ok_in    = 1'b1;
               fault_in = 1'b0;
               if (!req_range_ok) begin
                  ok_in    = 1'b0;
                  fault_in = (req_func == FUNC_ENQ) || (req_func == FUNC_CONSUME);
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_CHIP;
               end
            end
         end
         ST_CHIP: begin
            off_in = '0;
            if (32'(chip_ff) >= NCH || !range_ok_ff) begin
               if (!apply_ff && ok_ff &&
                   (func_ff == FUNC_ENQ || func_ff == FUNC_CONSUME)) begin
                  apply_in = 1'b1;
                  chip_in  = '0;
                  state_in = ST_APPLY;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (!chip_sel) begin
               chip_in = chip_ff + CHW'(1);
            end else begin
               unique case (func_ff)
                  FUNC_CHECK_ENQ: begin
                     if (fill_cur >= limit_eff) begin
                        ok_in   = 1'b0;
                        chip_in = chip_ff + CHW'(1);
                     end else if (fill_cur == '0) begin
                        chip_in = chip_ff + CHW'(1);
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  FUNC_ENQ: begin
                     if (32'(fill_cur) >= QUEUE_DEPTH) begin
                        ok_in    = 1'b0;
                        fault_in = 1'b1;
                     end
                     chip_in = chip_ff + CHW'(1);
                  end
                  FUNC_CHECK_RDY: begin
                     if (fill_cur == '0) begin
                        ok_in   = 1'b0;
                        chip_in = chip_ff + CHW'(1);
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     if (fill_cur == '0) begin
                        ok_in    = 1'b0;
                        fault_in = 1'b1;
                     end
                     chip_in = chip_ff + CHW'(1);
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (func_ff == FUNC_CHECK_RDY) begin
               if (rd_tag_ff != tag_ff || rd_due_ff > now_ff) begin
                  ok_in = 1'b0;
               end
               chip_in  = chip_ff + CHW'(1);
               state_in = ST_CHIP;
            end else begin
               if ((rd_tag_ff & DUP_MASK) == (tag_ff & DUP_MASK)) begin
                  ok_in = 1'b0;
               end
               if (off_ff + CW'(1) >= fill_cur) begin
                  chip_in  = chip_ff + CHW'(1);
                  state_in = ST_CHIP;
               end else begin
                  off_in   = off_ff + CW'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_APPLY: begin
            if (32'(chip_ff) >= NCH) begin
               state_in = ST_DONE;
            end else begin
               chip_in = chip_ff + CHW'(1);
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;
   assign rsp_fault   = rsp_fault_ff;

`ifndef SYNTHESIS
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid)
      else $error("result strobe missing");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_fault_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> !rsp_allowed)
      else $error("fault with allowed");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_cur) <= QUEUE_DEPTH)
      else $error("queue fill above depth");
`endif

endmodule

// ===== bench/multi_chip_target_queues_tb.sv =====
`timescale 1ns / 100ps
//----------------------------------------------------------------------------
// multi_chip_target_queues_tb
// Drives check, push, ready and pop transactions at the target queues and
// compares each strobed result against an in-bench queue predictor. The run
// steps through several queue limits, a directed opening and random traffic
// built mostly from push / ready / pop sequences on matching targets.
//----------------------------------------------------------------------------
module multi_chip_target_queues_tb;
   import mctq_pkg::*;

   localparam int NCH   = 2;
   localparam int NRK   = 2;
   localparam int NCP   = 8;
   localparam int DEPTH = 16;
   localparam int NQ    = NCH * NRK * NCP;

   typedef struct {
      func_type          func;
      logic              channel;
      logic              rank;
      logic [7:0]        chip_mask;
      logic [7:0]        context_id;
      logic [15:0]       group_id;
      logic [15:0]       occurrence_index;
      logic [7:0]        command_code;
      logic [3:0]        operand_slot;
      logic [TIME_W-1:0] ready_time;
      logic [TIME_W-1:0] now_time;
   } target_type;

   typedef struct {
      logic allowed;
      logic fault;
   } verdict_type;

   class queue_scoreboard;
      logic [TAG_W-1:0]  tag_mem[NQ][DEPTH];
      logic [TIME_W-1:0] due_mem[NQ][DEPTH];
      int                head[NQ];
      int                fill[NQ];
      int                limit;
      verdict_type       pending[$];
      int                errors;

      function void clear();
         foreach (head[q]) begin
            head[q] = 0;
            fill[q] = 0;
         end
         limit  = 16;
         errors = 0;
         pending.delete();
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] v);
         limit = v;
      endfunction

      function void note_request(target_type t);
         logic [TAG_W-1:0] tag;
         logic [TAG_W-1:0] dup;
         int       lim, base, q, s;
         bit       ok, flt;
         verdict_type v;
         tag = {t.context_id, t.group_id, t.occurrence_index, t.command_code,
                t.operand_slot};
         dup = {8'hFF, 16'h0, 16'hFFFF, 12'h0};
         lim = limit > DEPTH ? DEPTH : limit;
         ok  = 1;
         flt = 0;
         base = (t.channel * NRK + t.rank) * NCP;
         for (int c = 0; c < NCP; c++) begin
            if (!t.chip_mask[c]) continue;
            q = base + c;
            case (t.func)
               FUNC_CHECK_ENQ: begin
                  if (fill[q] >= lim) ok = 0;
                  else
                     for (int i = 0; i < fill[q]; i++)
                        if ((tag_mem[q][(head[q] + i) % DEPTH] & dup) == (tag & dup))
                           ok = 0;
               end
               FUNC_ENQ: if (fill[q] >= DEPTH) begin
                  ok = 0;
                  flt = 1;
               end
               FUNC_CHECK_RDY: begin
                  if (fill[q] == 0) ok = 0;
                  else if (tag_mem[q][head[q]] != tag || due_mem[q][head[q]] > t.now_time)
                     ok = 0;
               end
               default: if (fill[q] == 0) begin
                  ok = 0;
                  flt = 1;
               end
            endcase
         end
         if (ok && (t.func == FUNC_ENQ || t.func == FUNC_CONSUME))
            for (int c = 0; c < NCP; c++) begin
               if (!t.chip_mask[c]) continue;
               q = base + c;
               if (t.func == FUNC_ENQ) begin
                  s = (head[q] + fill[q]) % DEPTH;
                  tag_mem[q][s] = tag;
                  due_mem[q][s] = t.ready_time;
                  fill[q]++;
               end else begin
                  head[q] = (head[q] + 1) % DEPTH;
                  fill[q]--;
               end
            end
         v.allowed = ok;
         v.fault   = flt;
         pending.insert(pending.size(), v);
      endfunction

      function void check_result(logic allowed, logic fault);
         verdict_type e;
         if (pending.size() == 0) begin
            $error("unexpected result allowed=%0b fault=%0b", allowed, fault);
            errors++;
            return;
         end
         e = pending[0];
         pending.delete(0);
         if (allowed !== e.allowed) begin
            $error("allowed: expected %0b, actual %0b", e.allowed, allowed);
            errors++;
         end
         if (fault !== e.fault) begin
            $error("fault: expected %0b, actual %0b", e.fault, fault);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic [1:0]        req_func = '0;
   logic              req_channel = 0;
   logic              req_rank = 0;
   logic [7:0]        req_chip_mask = '0;
   logic [7:0]        req_context_id = '0;
   logic [15:0]       req_group_id = '0;
   logic [15:0]       req_occurrence_index = '0;
   logic [7:0]        req_command_code = '0;
   logic [3:0]        req_operand_slot = '0;
   logic [TIME_W-1:0] req_ready_time = '0;
   logic [TIME_W-1:0] req_now_time = '0;
   logic              rsp_valid, rsp_allowed, rsp_fault;
   logic              csr_we = 0;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   queue_scoreboard board = new();
   target_type      pool[$];
   int              burst_left = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   multi_chip_target_queues u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_channel(req_channel), .req_rank(req_rank),
      .req_chip_mask(req_chip_mask), .req_context_id(req_context_id),
      .req_group_id(req_group_id), .req_occurrence_index(req_occurrence_index),
      .req_command_code(req_command_code), .req_operand_slot(req_operand_slot),
      .req_ready_time(req_ready_time), .req_now_time(req_now_time),
      .rsp_valid(rsp_valid), .rsp_allowed(rsp_allowed), .rsp_fault(rsp_fault),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always @(posedge clock)
      if (!reset && rsp_valid) board.check_result(rsp_allowed, rsp_fault);

   task automatic send(target_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start                <= 1;
      req_func             <= t.func;
      req_channel          <= t.channel;
      req_rank             <= t.rank;
      req_chip_mask        <= t.chip_mask;
      req_context_id       <= t.context_id;
      req_group_id         <= t.group_id;
      req_occurrence_index <= t.occurrence_index;
      req_command_code     <= t.command_code;
      req_operand_slot     <= t.operand_slot;
      req_ready_time       <= t.ready_time;
      req_now_time         <= t.now_time;
      do @(posedge clock); while (busy);
      board.note_request(t);
   endtask

   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] v);
      drain();
      csr_we    <= 1;
      csr_wdata <= v;
      @(posedge clock);
      board.set_limit(v);
      csr_we <= 0;
   endtask

   function automatic target_type random_target();
      target_type t;
      t.func             = func_type'($urandom_range(0, 3));
      t.channel          = 1'($urandom_range(0, 1));
      t.rank             = 1'($urandom_range(0, 1));
      t.chip_mask        = 8'($urandom_range(0, 255));
      t.context_id       = 8'($urandom_range(0, 255));
      t.group_id         = 16'($urandom_range(0, 65535));
      t.occurrence_index = 16'($urandom_range(0, 65535));
      t.command_code     = 8'($urandom_range(0, 255));
      t.operand_slot     = 4'($urandom_range(0, 15));
      t.ready_time       = TIME_W'({$urandom(), $urandom()});
      t.now_time         = TIME_W'({$urandom(), $urandom()});
      return t;
   endfunction

   function automatic target_type small_target();
      target_type t;
      t = random_target();
      t.chip_mask        = 8'h1 << $urandom_range(0, 7);
      if ($urandom_range(0, 2) == 0) t.chip_mask |= 8'($urandom_range(0, 255));
      t.context_id       = 8'($urandom_range(0, 3));
      t.occurrence_index = 16'($urandom_range(0, 3));
      t.ready_time       = TIME_W'($urandom_range(0, 1000));
      return t;
   endfunction

   task automatic do_sequence();
      target_type t;
      int len;
      t = small_target();
      len = $urandom_range(1, 4);
      t.func = FUNC_CHECK_ENQ;
      send(t);
      t.func = FUNC_ENQ;
      repeat (len) send(t);
      pool.insert(pool.size(), t);
      if (pool.size() > 40 || $urandom_range(0, 1)) begin
         t = pool[0];
         pool.delete(0);
         t.func = FUNC_CHECK_RDY;
         t.now_time = $urandom_range(0, 1) ?
                      TIME_W'(t.ready_time + TIME_W'($urandom_range(0, 5))) :
                      TIME_W'(t.ready_time - TIME_W'(1));
         send(t);
         t.func = FUNC_CONSUME;
         send(t);
      end
   endtask

   initial begin
      target_type t;
      logic [LIMIT_W-1:0] limits[5];
      limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7};
      board.clear();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      t = random_target();
      t.channel = 1'b0; t.rank = 1'b0; t.chip_mask = 8'h00;
      for (int f = 0; f < 4; f++) begin
         t.func = func_type'(f);
         send(t);
      end
      t.chip_mask = 8'h81;
      t.func = FUNC_CONSUME;  send(t);
      t.func = FUNC_CHECK_RDY; send(t);
      t.context_id = 8'hFF; t.group_id = 16'hFFFF; t.occurrence_index = 16'hFFFF;
      t.command_code = 8'hFF; t.operand_slot = 4'hF;
      t.ready_time = '1; t.now_time = '1; t.channel = 1'b1; t.rank = 1'b1;
      t.chip_mask = 8'hFF;
      for (int i = 0; i < 17; i++) begin
         t.func = FUNC_ENQ;
         send(t);
      end
      t.func = FUNC_CHECK_ENQ; send(t);
      t.func = FUNC_CHECK_RDY; send(t);
      t.now_time = '0;         send(t);

      for (int p = 0; p < 5; p++) begin
         write_limit(limits[p]);
         for (int n = 0; n < 370;) begin
            if ($urandom_range(0, 3) != 0) begin
               do_sequence();
               n += 6;
            end else begin
               send(random_target());
               n++;
            end
         end
         for (int i = 0; i < 20; i++) begin
            t = random_target();
            t.func = FUNC_CONSUME;
            t.chip_mask = 8'hFF;
            send(t);
         end
         pool.delete();
      end

      drain();
      if (board.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #200ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
